### design/scti_pkg.sv
// Shared types and constants for the sorted curve table interpolator.
`default_nettype none
package scti_pkg;
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_GROUP = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic [15:0] UNITY = 16'd16384;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;    // latch input beat
		logic rd_issue;   // issue RAM read at rd_addr
		logic rd_take;    // RAM data valid this cycle
		logic wr_shift;   // write last read entry one place up
		logic wr_new;     // write new point at current position
		logic div_start;  // load the serial divider
		logic div_step;   // one quotient bit
		logic cnt_inc;    // bump the group's point count
		logic cnt_clr;    // clear all counts
		logic res_load;   // present result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic grp_bad;
		logic full;
		logic empty;
		logic pos_zero;   // insert position reached bottom
		logic key_gt;     // new key below read key (insert shifts)
		logic scan_done;  // lookup resolved
		logic need_div;   // lookup needs interpolation divide
		logic div_done;
	} stat_t;
endpackage
`default_nettype wire

### design/scti_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module scti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### design/scti_ctrl.sv
// Controller state machine for the sorted curve table interpolator.
`default_nettype none
module scti_ctrl
	import scti_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] opcode,
	input  wire stat_t      st,
	output logic            busy,
	output cmd_t            cmd
);
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DEC    = 9'b000000010,
		S_IRD    = 9'b000000100,
		S_IWAIT  = 9'b000001000,
		S_ICMP   = 9'b000010000,
		S_LRD    = 9'b000100000,
		S_LWAIT  = 9'b001000000,
		S_LCMP   = 9'b010000000,
		S_DIV    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
		end else begin
			state_q <= state_d;
			if (start && !busy) op_q <= opcode;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (op_q == OP_CLEAR) begin
					cmd.cnt_clr  = 1'b1;
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end else if (op_q == OP_INSERT && !st.grp_bad && !st.full) begin
					if (st.pos_zero) begin
						cmd.wr_new   = 1'b1;
						cmd.cnt_inc  = 1'b1;
						cmd.res_load = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.rd_issue = 1'b1;
						state_d = S_IWAIT;
					end
				end else if (op_q == OP_LOOKUP && !st.grp_bad && !st.empty) begin
					cmd.rd_issue = 1'b1;
					state_d = S_LWAIT;
				end else begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_IWAIT: begin
				cmd.rd_take = 1'b1;
				state_d = S_ICMP;
			end
			S_ICMP: begin
				if (st.key_gt) begin
					cmd.wr_shift = 1'b1;
					state_d = S_IRD;
				end else begin
					cmd.wr_new   = 1'b1;
					cmd.cnt_inc  = 1'b1;
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_IRD: begin
				if (st.pos_zero) begin
					cmd.wr_new   = 1'b1;
					cmd.cnt_inc  = 1'b1;
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = S_IWAIT;
				end
			end
			S_LWAIT: begin
				cmd.rd_take = 1'b1;
				state_d = S_LCMP;
			end
			S_LCMP: begin
				priority if (st.scan_done && st.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else if (st.scan_done) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_LRD;
				end
			end
			S_LRD: begin
				cmd.rd_issue = 1'b1;
				state_d = S_LWAIT;
			end
			S_DIV: begin
				if (st.div_done) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> state_q == S_IDLE)
		else $error("capture outside idle");
	a_result_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> !busy)
		else $error("result without return to idle");
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_new && cmd.wr_shift))
		else $error("two writes in one cycle");
endmodule
`default_nettype wire

### design/scti_dp.sv
// Datapath: curve memory, point counts, scan registers and serial divider.
`default_nettype none
module scti_dp
	import scti_pkg::*;
#(
	parameter int GROUPS     = 3,
	parameter int MAX_POINTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            st,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  group,
	input  wire logic [15:0] level,
	input  wire logic [15:0] factor_in,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      factor_out,
	output logic [4:0]       point_count
);
	localparam int DEPTH = GROUPS * MAX_POINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(MAX_POINTS + 1);
	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	// Beat capture
	logic [1:0]  op_q;
	logic [1:0]  grp_q;
	logic [15:0] lvl_q;
	logic [15:0] fac_q;
	logic [PW-1:0] cnt_q [GROUPS];
	logic [31:0]   tail_q [GROUPS];   // last (highest) entry of each curve
	logic [PW-1:0] pos_q;   // insert: hole; lookup: next index to read

	logic grp_ok;
	logic [GW-1:0] gidx;
	logic [PW-1:0] cur_cnt;
	assign grp_ok  = ({30'd0, grp_q} < GROUPS);
	assign gidx    = grp_q[GW-1:0];
	assign cur_cnt = grp_ok ? cnt_q[gidx] : '0;

	// Count of the group on the input ports, for the start position
	logic          in_ok;
	logic [PW-1:0] in_cnt;
	assign in_ok  = ({30'd0, group} < GROUPS);
	assign in_cnt = in_ok ? cnt_q[group[GW-1:0]] : '0;

	// RAM
	logic          we;
	logic [AW-1:0] waddr, raddr, base;
	logic [31:0]   wdata, rdata;
	logic [31:0]   ent_q;     // last entry read
	logic [31:0]   prev_q;    // lookup: previous entry
	assign base = AW'(gidx * MAX_POINTS);

	scti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign raddr = base + AW'(pos_q - ((op_q == OP_INSERT) ? PW'(1) : PW'(0)));
	assign we    = cmd.wr_shift | cmd.wr_new;
	assign waddr = base + AW'(pos_q);
	assign wdata = cmd.wr_new ? {lvl_q, fac_q} : ent_q;

	// Lookup evaluation on freshly read entry (rd_take registered into ent_q)
	logic signed [15:0] x, ek, pk, tk;
	logic first_rd;
	assign x  = lvl_q;
	assign ek = ent_q[31:16];
	assign pk = prev_q[31:16];
	assign tk = tail_q[gidx][31:16];
	assign first_rd = (pos_q == PW'(1));

	// Divider: |x-g0| * |f1-f0| / (g1-g0)
	logic [32:0] num_q;
	logic [16:0] den_q;
	logic [16:0] rem_q;
	logic [5:0]  dcnt_q;
	logic        neg_q;
	logic [15:0] f0_q;
	logic [17:0] trial;
	assign trial = {rem_q, num_q[32]} - {1'b0, den_q};

	logic [15:0] fout_q;
	logic [1:0]  stat_q;
	logic        res_direct;   // lookup resolved without divide
	logic [15:0] res_val;

	logic [16:0] span, dx;
	logic [16:0] df;
	logic        dneg;
	logic [33:0] prod;
	assign span = 17'(signed'({ek[15], ek}) - signed'({pk[15], pk}));
	assign dx   = 17'(signed'({x[15], x}) - signed'({pk[15], pk}));
	assign dneg = ent_q[15:0] < prev_q[15:0];
	assign df   = dneg ? 17'(prev_q[15:0] - ent_q[15:0]) : 17'(ent_q[15:0] - prev_q[15:0]);
	assign prod = dx * df;

	// clamp at or below the first key, then at or above the last key
	always_comb begin
		res_direct = 1'b0;
		res_val    = ent_q[15:0];
		if (first_rd && x <= ek) res_direct = 1'b1;
		else if (first_rd && x >= tk) begin
			res_direct = 1'b1;
			res_val    = tail_q[gidx][15:0];
		end
	end

	// past the first entry x lies below the last key, so a later key bounds it
	assign st.grp_bad   = !grp_ok;
	assign st.full      = grp_ok && (cnt_q[gidx] >= PW'(MAX_POINTS));
	assign st.empty     = grp_ok && (cnt_q[gidx] == '0);
	assign st.pos_zero  = (pos_q == '0);
	assign st.key_gt    = x < ek;
	assign st.scan_done = res_direct || (!first_rd && x <= ek);
	assign st.need_div  = !res_direct;
	assign st.div_done  = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) cnt_q[g] <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.res_load;
			if (cmd.cnt_clr)
				for (int g = 0; g < GROUPS; g++) cnt_q[g] <= '0;
			else if (cmd.cnt_inc)
				cnt_q[gidx] <= cnt_q[gidx] + PW'(1);
		end
	end

	// Scan / divide registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			grp_q <= group;
			lvl_q <= level;
			fac_q <= factor_in;
		end
		if (cmd.capture) pos_q <= (opcode == OP_INSERT) ? in_cnt : '0;
		else if (cmd.wr_shift) pos_q <= pos_q - PW'(1);
		else if (op_q == OP_LOOKUP && cmd.rd_issue) pos_q <= pos_q + PW'(1);
		// a point placed at the end becomes the new tail
		if (cmd.wr_new && pos_q == cur_cnt)
			tail_q[gidx] <= {lvl_q, fac_q};
		if (cmd.rd_take) begin
			ent_q  <= rdata;
			prev_q <= ent_q;
		end
		if (cmd.div_start) begin
			num_q  <= prod[32:0];
			den_q  <= span;
			rem_q  <= '0;
			dcnt_q <= 6'd33;
			neg_q  <= dneg;
			f0_q   <= prev_q[15:0];
		end else if (cmd.div_step) begin
			if (!trial[17]) rem_q <= trial[16:0];
			else rem_q <= {rem_q[15:0], num_q[32]};
			num_q  <= {num_q[31:0], !trial[17]};
			dcnt_q <= dcnt_q - 6'd1;
		end
		if (cmd.res_load) begin
			stat_q <= ST_OK;
			fout_q <= UNITY;
			point_count <= 5'(cur_cnt);
			unique case (op_q)
				OP_INSERT: begin
					if (!grp_ok) stat_q <= ST_BAD_GROUP;
					else if (cur_cnt >= PW'(MAX_POINTS)) stat_q <= ST_FULL;
					else point_count <= 5'(cur_cnt + PW'(1));
				end
				OP_LOOKUP: begin
					if (!grp_ok) stat_q <= ST_BAD_GROUP;
					else if (cur_cnt == '0) stat_q <= ST_EMPTY;
					else if (!res_direct)
						fout_q <= neg_q ? f0_q - num_q[15:0] : f0_q + num_q[15:0];
					else fout_q <= res_val;
				end
				OP_CLEAR: point_count <= '0;
				default: ;
			endcase
		end
	end

	assign status     = stat_q;
	assign factor_out = fout_q;
endmodule
`default_nettype wire

### design/sorted_curve_table_interpolator_top.sv
// Top level of the sorted curve table interpolator.
// Usage: drive opcode, group, level and factor_in with start high while
// busy is low; that beat is taken at the rising edge. One result beat
// follows: done pulses for one cycle with status, factor_out and point_count
// valid in that cycle. The receiver cannot stall; results must be captured
// when done is high. Done is high in the first cycle with busy low, and the
// next beat can be taken at the edge ending that cycle.
// Clear, rejected items and an insert into an empty curve end in decode.
// Insert: a read, wait and compare through the single RAM read port per
// point moved up, plus a wait and compare when the new point stops above
// a stored one. Lookup: a read, wait and compare per point scanned, plus
// the bit-serial divide when interpolating.
// Reset clears all point counts, so every curve starts empty; the curve
// RAM itself is not cleared and needs no pass.
`default_nettype none
module sorted_curve_table_interpolator_top
	import scti_pkg::*;
#(
	parameter int GROUPS     = 3,
	parameter int MAX_POINTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  group,
	input  wire logic signed [15:0] level,
	input  wire logic [15:0] factor_in,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      factor_out,
	output logic [4:0]       point_count
);
	cmd_t  cmd;
	stat_t st;

	scti_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.st(st), .busy(busy), .cmd(cmd)
	);

	scti_dp #(.GROUPS(GROUPS), .MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.opcode(opcode), .group(group), .level(level), .factor_in(factor_in),
		.done(done), .status(status), .factor_out(factor_out),
		.point_count(point_count)
	);
endmodule
`default_nettype wire
